// File: design/uart_crc8_frame_receiver_assert.svh
// ----------------------------------------------------------------------------
// uart_crc8_frame_receiver_assert.svh
// Assertion macros for the CRC-8 serial frame receiver.
// ----------------------------------------------------------------------------
`ifndef UART_CRC8_FRAME_RECEIVER_ASSERT_SVH
`define UART_CRC8_FRAME_RECEIVER_ASSERT_SVH

// same-cycle implication, sampled on clock, off during reset
`define UCFR_ASSERT_IMP(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("ucfr assertion failed");

// next-cycle implication, sampled on clock, off during reset
`define UCFR_ASSERT_NXT(name, ante, cons) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("ucfr assertion failed");

`endif

// File: design/ucfr_pkg.sv
// ----------------------------------------------------------------------------
// ucfr_pkg
// Shared constants, types and the CRC-8 step for the serial frame receiver.
// ----------------------------------------------------------------------------
package ucfr_pkg;

   localparam int BUF_DEPTH   = 64;
   localparam int PAYLOAD_MAX = BUF_DEPTH - 8;
   localparam int ADDR_W      = $clog2(PAYLOAD_MAX);
   localparam int CNT_W       = $clog2(BUF_DEPTH) + 1;

   localparam logic [7:0] SYNC1_BYTE  = 8'h55;
   localparam logic [7:0] SYNC2_BYTE  = 8'haa;
   localparam logic [7:0] BCAST_ADDR  = 8'hff;
   localparam logic [7:0] TRAIL1_BYTE = 8'hbb;
   localparam logic [7:0] TRAIL2_BYTE = 8'hcc;
   localparam logic [7:0] CRC_POLY    = 8'h31;

   localparam int POS_SYNC2   = 1;
   localparam int POS_ADDR    = 2;
   localparam int POS_CMD     = 3;
   localparam int POS_LEN     = 4;
   localparam int POS_PAYLOAD = 5;
   localparam int OFS_TRAIL1  = 6;
   localparam int OFS_TRAIL2  = 7;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_FMT_ERR = 2'd1;
   localparam logic [1:0] STATUS_CRC_ERR = 2'd2;

   typedef enum logic [1:0] {
      ST_RECV,
      ST_READ,
      ST_LOAD
   } ucfr_state_type;

   typedef struct packed {
      logic take;
      logic rd_en;
      logic load;
   } ucfr_cmd_type;

   typedef struct packed {
      logic start_emit;
      logic last_index;
      logic out_free;
   } ucfr_stat_type;

   function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
      logic [7:0] v;
      v = crc ^ b;
      for (int i = 0; i < 8; i++) begin
         v = v[7] ? ((v << 1) ^ CRC_POLY) : (v << 1);
      end
      return v;
   endfunction

endpackage

// File: design/ucfr_ram.sv
// ----------------------------------------------------------------------------
// ucfr_ram
// Simple dual-port RAM, one write port, one registered read port.
// ----------------------------------------------------------------------------
module ucfr_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 56
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: design/ucfr_ctrl.sv
// ----------------------------------------------------------------------------
// ucfr_ctrl
// Controller: byte intake and payload readout sequencing.
// ----------------------------------------------------------------------------
module ucfr_ctrl
   import ucfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          req_tvalid,
   output logic          req_tready,
   input  ucfr_stat_type stat,
   output ucfr_cmd_type  cmd
);

   ucfr_state_type state_ff;
   ucfr_state_type state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_RECV;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      req_tready = 1'b0;
      cmd        = '0;
      case (state_ff)
         ST_RECV: begin
            req_tready = stat.out_free;
            cmd.take   = req_tvalid && stat.out_free;
            if (cmd.take && stat.start_emit) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd.rd_en = 1'b1;
            state_in  = ST_LOAD;
         end
         ST_LOAD: begin
            if (stat.out_free) begin
               cmd.load = 1'b1;
               state_in = stat.last_index ? ST_RECV : ST_READ;
            end
         end
         default: begin
            state_in = ST_RECV;
         end
      endcase
   end

endmodule

// File: design/ucfr_datapath.sv
// ----------------------------------------------------------------------------
// ucfr_datapath
// Datapath: frame parsing, CRC-8, payload store and result register.
// ----------------------------------------------------------------------------
module ucfr_datapath
   import ucfr_pkg::*;
(
   input  logic          clock,
   input  logic          reset,
   input  logic          csr_we,
   input  logic [7:0]    csr_wdata,
   input  logic [7:0]    rx_byte,
   input  ucfr_cmd_type  cmd,
   output ucfr_stat_type stat,
   input  logic          rsp_tready,
   output logic          rsp_valid,
   output logic [1:0]    rsp_status,
   output logic [7:0]    rsp_command,
   output logic [5:0]    rsp_length,
   output logic          rsp_has_payload,
   output logic [7:0]    rsp_payload_byte,
   output logic [5:0]    rsp_byte_index,
   output logic          rsp_last
);

   logic [7:0]       own_addr_ff;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [7:0]       crc_ff, crc_in, crc_step;
   logic             hok_ff, hok_in, hok_next;
   logic [7:0]       cmd_ff, cmd_in;
   logic [7:0]       len_ff, len_in;
   logic [ADDR_W-1:0] idx_ff;
   logic [8:0]       c9, len9;
   logic             wr_en, emit, start_emit;
   logic [1:0]       e_status;
   logic [7:0]       e_cmd;
   logic [7:0]       rd_data;

   logic             valid_ff;
   logic [1:0]       status_ff;
   logic [7:0]       command_ff;
   logic [5:0]       length_ff;
   logic             has_ff;
   logic [7:0]       pbyte_ff;
   logic [5:0]       bidx_ff;
   logic             last_ff;

   assign c9       = 9'(count_ff);
   assign len9     = {1'b0, len_ff};
   assign crc_step = crc8_update(crc_ff, rx_byte);

   always_comb begin
      count_in   = count_ff;
      crc_in     = crc_ff;
      hok_in     = hok_ff;
      hok_next   = hok_ff;
      cmd_in     = cmd_ff;
      len_in     = len_ff;
      wr_en      = 1'b0;
      emit       = 1'b0;
      start_emit = 1'b0;
      e_status   = STATUS_OK;
      e_cmd      = 8'd0;
      if (count_ff == '0) begin
         if (rx_byte == SYNC1_BYTE) begin
            count_in = CNT_W'(1);
            crc_in   = 8'd0;
            hok_in   = 1'b1;
         end
      end else begin
         if (count_ff == CNT_W'(POS_SYNC2) && rx_byte != SYNC2_BYTE) begin
            hok_next = 1'b0;
         end
         if (count_ff == CNT_W'(POS_ADDR) && rx_byte != own_addr_ff &&
             rx_byte != BCAST_ADDR) begin
            hok_next = 1'b0;
         end
         if (c9 == len9 + 9'(OFS_TRAIL1) && rx_byte != TRAIL1_BYTE) begin
            hok_next = 1'b0;
         end
         hok_in = hok_next;
         if (count_ff >= CNT_W'(POS_ADDR) &&
             (count_ff < CNT_W'(POS_PAYLOAD) || c9 <= len9 + 9'(POS_PAYLOAD))) begin
            crc_in = crc_step;
         end
         if (count_ff == CNT_W'(POS_CMD)) begin
            cmd_in = rx_byte;
         end
         if (count_ff >= CNT_W'(POS_PAYLOAD) && c9 < len9 + 9'(POS_PAYLOAD)) begin
            wr_en = 1'b1;
         end
         if (count_ff == CNT_W'(POS_LEN)) begin
            len_in = rx_byte;
            if (rx_byte > 8'(PAYLOAD_MAX)) begin
               emit     = 1'b1;
               e_status = STATUS_FMT_ERR;
               count_in = '0;
               crc_in   = 8'd0;
               hok_in   = 1'b1;
            end else begin
               count_in = CNT_W'(POS_PAYLOAD);
            end
         end else if (c9 == len9 + 9'(OFS_TRAIL2)) begin
            count_in = '0;
            crc_in   = 8'd0;
            hok_in   = 1'b1;
            if (!(hok_next && rx_byte == TRAIL2_BYTE)) begin
               emit     = 1'b1;
               e_status = STATUS_FMT_ERR;
            end else if (crc_ff != 8'd0) begin
               emit     = 1'b1;
               e_status = STATUS_CRC_ERR;
            end else if (len_ff == 8'd0) begin
               emit  = 1'b1;
               e_cmd = cmd_ff;
            end else begin
               start_emit = 1'b1;
            end
         end else begin
            count_in = count_ff + CNT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         own_addr_ff <= 8'd0;
         count_ff    <= '0;
         crc_ff      <= 8'd0;
         hok_ff      <= 1'b1;
         cmd_ff      <= 8'd0;
         len_ff      <= 8'd0;
         idx_ff      <= '0;
         valid_ff    <= 1'b0;
      end else begin
         if (csr_we) begin
            own_addr_ff <= csr_wdata;
         end
         if (cmd.take) begin
            count_ff <= count_in;
            crc_ff   <= crc_in;
            hok_ff   <= hok_in;
            cmd_ff   <= cmd_in;
            len_ff   <= len_in;
         end
         if (cmd.take && start_emit) begin
            idx_ff <= '0;
         end else if (cmd.load) begin
            idx_ff <= idx_ff + ADDR_W'(1);
         end
         if ((cmd.take && emit) || cmd.load) begin
            valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.take && emit) begin
         status_ff  <= e_status;
         command_ff <= e_cmd;
         length_ff  <= 6'd0;
         has_ff     <= 1'b0;
         pbyte_ff   <= 8'd0;
         bidx_ff    <= 6'd0;
         last_ff    <= 1'b1;
      end else if (cmd.load) begin
         status_ff  <= STATUS_OK;
         command_ff <= cmd_ff;
         length_ff  <= len_ff[5:0];
         has_ff     <= 1'b1;
         pbyte_ff   <= rd_data;
         bidx_ff    <= 6'(idx_ff);
         last_ff    <= stat.last_index;
      end
   end

   ucfr_ram #(
      .WIDTH (8),
      .DEPTH (PAYLOAD_MAX)
   ) u_store (
      .clock   (clock),
      .wr_en   (cmd.take && wr_en),
      .wr_addr (ADDR_W'(count_ff - CNT_W'(POS_PAYLOAD))),
      .wr_data (rx_byte),
      .rd_en   (cmd.rd_en),
      .rd_addr (idx_ff),
      .rd_data (rd_data)
   );

   assign stat.start_emit = start_emit;
   assign stat.last_index = (9'(idx_ff) + 9'd1) == len9;
   assign stat.out_free   = !valid_ff || rsp_tready;

   assign rsp_valid        = valid_ff;
   assign rsp_status       = status_ff;
   assign rsp_command      = command_ff;
   assign rsp_length       = length_ff;
   assign rsp_has_payload  = has_ff;
   assign rsp_payload_byte = pbyte_ff;
   assign rsp_byte_index   = bidx_ff;
   assign rsp_last         = last_ff;

endmodule

// File: design/uart_crc8_frame_receiver.sv
// ----------------------------------------------------------------------------
// uart_crc8_frame_receiver
// Receives serial bytes, finds 55 AA framed packets, checks address, trailer
// and CRC-8 (poly 0x31), and emits command and payload words per frame.
//
// Usage:
//   req_*  : one received byte per word, taken when the result register is
//            free or being emptied in the same cycle; one byte per cycle outside payload readout.
//   rsp_*  : result words; one error word or empty-frame word per bad or
//            zero-length frame, or one word per payload byte; tlast on the
//            final word of a frame.
//   csr_*  : own station address, written while the block is idle.
// Output: an error or empty-frame word is valid the cycle after the final
// byte is taken (or the length byte, when the length is too large); each
// payload word is read from the registered RAM and then loaded into the result
// register once it is free; req_tready stays low until the last payload word loads.
// Reset: returns to searching for 55, address 0, no result pending. There
// is no clearing pass; the payload RAM needs none.
// A stalled rsp_tready holds the result word and blocks new bytes.
// ----------------------------------------------------------------------------
module uart_crc8_frame_receiver
   import ucfr_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] rx_byte
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [7:0] command, [13:8] payload_length,
                                    // [21:14] payload_byte, [27:22] byte_index
   output logic [2:0]  rsp_tuser,   // [1:0] status, [2] has_payload
   output logic        rsp_tlast,
   input  logic        csr_we,
   input  logic [7:0]  csr_wdata
);

   ucfr_cmd_type  cmd;
   ucfr_stat_type stat;
   logic [1:0]    status;
   logic [7:0]    command;
   logic [5:0]    payload_length;
   logic          has_payload;
   logic [7:0]    payload_byte;
   logic [5:0]    byte_index;

   ucfr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .stat       (stat),
      .cmd        (cmd)
   );

   ucfr_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .csr_we           (csr_we),
      .csr_wdata        (csr_wdata),
      .rx_byte          (req_tdata),
      .cmd              (cmd),
      .stat             (stat),
      .rsp_tready       (rsp_tready),
      .rsp_valid        (rsp_tvalid),
      .rsp_status       (status),
      .rsp_command      (command),
      .rsp_length       (payload_length),
      .rsp_has_payload  (has_payload),
      .rsp_payload_byte (payload_byte),
      .rsp_byte_index   (byte_index),
      .rsp_last         (rsp_tlast)
   );

   assign rsp_tdata = {4'd0, byte_index, payload_byte, payload_length, command};
   assign rsp_tuser = {has_payload, status};

`include "uart_crc8_frame_receiver_assert.svh"

   `UCFR_ASSERT_IMP(a_stall_blocks_input, rsp_tvalid && !rsp_tready, !req_tready)
   `UCFR_ASSERT_IMP(a_single_word_is_last, rsp_tvalid && !rsp_tuser[2], rsp_tlast)
   `UCFR_ASSERT_IMP(a_error_word_zero, rsp_tvalid && (rsp_tuser[1:0] != STATUS_OK),
                    rsp_tdata == '0)
   `UCFR_ASSERT_NXT(a_payload_blocks_input,
                    rsp_tvalid && !rsp_tready && rsp_tuser[2] && !rsp_tlast, !req_tready)

endmodule

// File: verif/uart_crc8_frame_receiver_tb.sv
// ----------------------------------------------------------------------------
// uart_crc8_frame_receiver_tb
// Self-checking bench for the CRC-8 serial frame receiver. Directed frames
// come first: good, empty, broadcast, bad header, bad address, bad trailer,
// bad CRC and oversized length. Random frames follow, mostly well formed,
// with noise, faults and truncated frames mixed in. The station address is
// changed between phases. The directed table or a local deframer predicts
// every result word, and a monitor compares each word with the oldest
// prediction. Random idle cycles fall on both sides. One phase has a long
// output stall, and one phase has a pause in the input until all results are out.
// ----------------------------------------------------------------------------
module uart_crc8_frame_receiver_tb;
   import ucfr_pkg::*;

   localparam int DRAIN_CYCLES = 16;
   localparam int LONG_HOLD    = 400;
   localparam int PHASE_BYTES  = 50;
   localparam int NUM_PHASES   = 5;
   localparam int DIR_ROWS     = 13;

   localparam logic [3:0] NO_FAULT     = 4'b0000;
   localparam logic [3:0] FAULT_SYNC2  = 4'b0001;
   localparam logic [3:0] FAULT_CRC    = 4'b0010;
   localparam logic [3:0] FAULT_TRAIL1 = 4'b0100;
   localparam logic [3:0] FAULT_TRAIL2 = 4'b1000;

   typedef struct packed {
      logic [1:0] status;
      logic [7:0] command;
      logic [5:0] length;
      logic       has;
      logic [7:0] pbyte;
      logic [5:0] index;
      logic       last;
   } rsp_word_type;

   typedef struct {
      logic [7:0] noise;
      logic [7:0] addr;
      logic [7:0] cmd;
      logic [7:0] len;
      logic [3:0] faults;
      logic       alt;
      logic       typed;
      logic [1:0] status;
   } dir_row_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'h00;    // [7:0] rx_byte
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;            // [7:0] command, [13:8] payload_length,
                                      // [21:14] payload_byte, [27:22] byte_index
   logic [2:0]  rsp_tuser;            // [1:0] status, [2] has_payload
   logic        rsp_tlast;
   logic        csr_we = 1'b0;
   logic [7:0]  csr_wdata = 8'h00;

   // deframer state
   logic [7:0] station_addr = 8'h00;
   logic [6:0] frame_pos = '0;
   logic [7:0] frame_crc = 8'h00;
   logic       frame_good = 1'b1;
   logic [7:0] frame_cmd = 8'h00;
   logic [7:0] frame_len = 8'h00;
   logic [7:0] payload_mem [PAYLOAD_MAX];

   rsp_word_type frame_words [$];
   rsp_word_type words_due [$];
   logic [7:0]   frame_bytes [$];

   int   mismatches = 0;
   int   bytes_sent = 0;
   logic tx_idle = 1'b1;
   logic rx_idle = 1'b1;
   logic long_hold_req = 1'b0;

   dir_row_type dir_rows [DIR_ROWS] = '{
      '{8'h00, 8'h00, 8'h00, 8'd0,   NO_FAULT,                 1'b0, 1'b1, STATUS_OK},
      '{8'hFF, 8'hFF, 8'hFF, 8'd1,   NO_FAULT,                 1'b0, 1'b0, STATUS_OK},
      '{8'hAA, 8'h00, 8'h5A, 8'd2,   NO_FAULT,                 1'b1, 1'b0, STATUS_OK},
      '{8'h56, 8'h00, 8'h01, 8'd0,   FAULT_SYNC2,              1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h00, 8'h12, 8'h02, 8'd0,   NO_FAULT,                 1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h54, 8'hFF, 8'h03, 8'd3,   FAULT_TRAIL1,             1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h00, 8'h00, 8'h04, 8'd1,   FAULT_TRAIL2,             1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h00, 8'h00, 8'h05, 8'd4,   FAULT_CRC,                1'b0, 1'b1, STATUS_CRC_ERR},
      '{8'h00, 8'h00, 8'h06, 8'd0,   FAULT_CRC | FAULT_TRAIL2, 1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h00, 8'h00, 8'h07, 8'd57,  NO_FAULT,                 1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h00, 8'hFF, 8'h08, 8'd255, NO_FAULT,                 1'b0, 1'b1, STATUS_FMT_ERR},
      '{8'h00, 8'h00, 8'hC3, 8'd56,  NO_FAULT,                 1'b1, 1'b0, STATUS_OK},
      '{8'h00, 8'hFF, 8'h80, 8'd0,   NO_FAULT,                 1'b0, 1'b1, STATUS_OK}
   };

   uart_crc8_frame_receiver dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_we     (csr_we),
      .csr_wdata  (csr_wdata)
   );

   always #5 clock = ~clock;

   function automatic logic [7:0] crc8_next(input logic [7:0] crc, input logic [7:0] d);
      logic [7:0] r;
      r = crc;
      for (int k = 7; k >= 0; k--) begin
         r = {r[6:0], 1'b0} ^ ((r[7] ^ d[k]) ? CRC_POLY : 8'h00);
      end
      return r;
   endfunction

   function automatic void emit(input logic [1:0] st, input logic [7:0] cmd,
                                input logic [5:0] len, input logic has,
                                input logic [7:0] pb, input logic [5:0] idx,
                                input logic last);
      rsp_word_type w;
      w = '{status: st, command: cmd, length: len, has: has, pbyte: pb,
            index: idx, last: last};
      frame_words.push_back(w);
   endfunction

   function automatic void restart_frame();
      frame_pos  = '0;
      frame_crc  = 8'h00;
      frame_good = 1'b1;
   endfunction

   // advance the deframer by one byte; result words go to frame_words
   function automatic void deframe_byte(input logic [7:0] b);
      logic [6:0] pos;
      logic [7:0] len;
      logic       fmt_ok;
      logic       crc_ok;
      pos = frame_pos;
      len = frame_len;
      frame_words.delete();
      if (pos == 0) begin
         if (b == SYNC1_BYTE) begin
            restart_frame();
            frame_pos = 7'd1;
         end
         return;
      end
      if (pos == POS_SYNC2 && b != SYNC2_BYTE) frame_good = 1'b0;
      if (pos == POS_ADDR && b != station_addr && b != BCAST_ADDR) frame_good = 1'b0;
      if (pos >= POS_ADDR && (pos < POS_PAYLOAD || pos <= POS_PAYLOAD + len))
         frame_crc = crc8_next(frame_crc, b);
      if (pos == POS_CMD) frame_cmd = b;
      if (pos == POS_LEN) begin
         frame_len = b;
         if (b > PAYLOAD_MAX) begin
            restart_frame();
            emit(STATUS_FMT_ERR, 8'h00, 6'd0, 1'b0, 8'h00, 6'd0, 1'b1);
         end else begin
            frame_pos = 7'(POS_PAYLOAD);
         end
         return;
      end
      if (pos >= POS_PAYLOAD && pos < POS_PAYLOAD + len) payload_mem[pos - POS_PAYLOAD] = b;
      if (pos == OFS_TRAIL1 + len && b != TRAIL1_BYTE) frame_good = 1'b0;
      if (pos == OFS_TRAIL2 + len) begin
         fmt_ok = frame_good && b == TRAIL2_BYTE;
         crc_ok = frame_crc == 8'h00;
         restart_frame();
         if (!fmt_ok) begin
            emit(STATUS_FMT_ERR, 8'h00, 6'd0, 1'b0, 8'h00, 6'd0, 1'b1);
         end else if (!crc_ok) begin
            emit(STATUS_CRC_ERR, 8'h00, 6'd0, 1'b0, 8'h00, 6'd0, 1'b1);
         end else if (len == 0) begin
            emit(STATUS_OK, frame_cmd, 6'd0, 1'b0, 8'h00, 6'd0, 1'b1);
         end else begin
            for (int i = 0; i < len; i++) begin
               emit(STATUS_OK, frame_cmd, len[5:0], 1'b1, payload_mem[i], 6'(i),
                    i == len - 1);
            end
         end
         return;
      end
      frame_pos = pos + 7'd1;
   endfunction

   function automatic logic [7:0] other_than(input logic [7:0] x);
      return x ^ 8'($urandom_range(1, 255));
   endfunction

   // fill frame_bytes with one frame; an oversized length ends it early
   function automatic void build_frame(input logic [7:0] addr, input logic [7:0] cmd,
                                       input logic [7:0] len, input logic [3:0] faults,
                                       input logic alt);
      logic [7:0] crc;
      logic [7:0] pb;
      frame_bytes.delete();
      frame_bytes.push_back(SYNC1_BYTE);
      frame_bytes.push_back((faults & FAULT_SYNC2) != 0 ? other_than(SYNC2_BYTE) : SYNC2_BYTE);
      frame_bytes.push_back(addr);
      frame_bytes.push_back(cmd);
      frame_bytes.push_back(len);
      if (len > PAYLOAD_MAX) return;
      crc = crc8_next(crc8_next(crc8_next(8'h00, addr), cmd), len);
      for (int i = 0; i < len; i++) begin
         pb = alt ? (i % 2 == 1 ? 8'hFF : 8'h00) : 8'($urandom_range(0, 255));
         crc = crc8_next(crc, pb);
         frame_bytes.push_back(pb);
      end
      if ((faults & FAULT_CRC) != 0) crc = crc ^ (8'h01 << $urandom_range(0, 7));
      frame_bytes.push_back(crc);
      frame_bytes.push_back((faults & FAULT_TRAIL1) != 0 ? other_than(TRAIL1_BYTE) : TRAIL1_BYTE);
      frame_bytes.push_back((faults & FAULT_TRAIL2) != 0 ? other_than(TRAIL2_BYTE) : TRAIL2_BYTE);
   endfunction

   task automatic send_byte(input logic [7:0] b, input logic typed,
                            input rsp_word_type typed_word);
      int gap;
      gap = tx_idle ? $urandom_range(0, 10) : 0;
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_tdata  <= b;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      if (frame_pos != 0 || b == SYNC1_BYTE) bytes_sent++;
      deframe_byte(b);
      if (typed) begin
         words_due.push_back(typed_word);
      end else begin
         foreach (frame_words[k]) words_due.push_back(frame_words[k]);
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (words_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_station_addr(input logic [7:0] v);
      drain_results();
      csr_wdata <= v;
      csr_we    <= 1'b1;
      @(posedge clock);
      csr_we    <= 1'b0;
      station_addr = v;
   endtask

   task automatic random_frame();
      int         sel;
      int         n;
      logic [7:0] addr;
      logic [7:0] len;
      logic [3:0] faults;
      if ($urandom_range(0, 7) == 0) tx_idle = !tx_idle;
      if ($urandom_range(0, 7) == 0) rx_idle = !rx_idle;
      if ($urandom_range(0, 3) == 0)
         repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)), 1'b0, '0);
      sel  = $urandom_range(0, 9);
      addr = sel < 4 ? station_addr : sel < 7 ? BCAST_ADDR : 8'($urandom_range(0, 255));
      sel  = $urandom_range(0, 19);
      len  = sel < 12 ? 8'($urandom_range(0, 4)) :
             sel < 16 ? 8'($urandom_range(5, 16)) :
             sel < 19 ? 8'($urandom_range(17, PAYLOAD_MAX)) :
                        8'($urandom_range(PAYLOAD_MAX + 1, 255));
      faults = $urandom_range(0, 4) == 0 ? 4'($urandom_range(1, 15)) : NO_FAULT;
      build_frame(addr, 8'($urandom_range(0, 255)), len, faults, $urandom_range(0, 7) == 0);
      n = frame_bytes.size();
      // drop the tail now and then
      if ($urandom_range(0, 19) == 0) n = $urandom_range(1, n - 1);
      for (int i = 0; i < n; i++) send_byte(frame_bytes[i], 1'b0, '0);
   endtask

   always @(posedge clock) begin : rsp_check
      rsp_word_type got;
      rsp_word_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = '{status: rsp_tuser[1:0], command: rsp_tdata[7:0], length: rsp_tdata[13:8],
                 has: rsp_tuser[2], pbyte: rsp_tdata[21:14], index: rsp_tdata[27:22],
                 last: rsp_tlast};
         if (words_due.size() == 0) begin
            if (mismatches < 10)
               $display({"unexpected rsp word: st=%0d cmd=%h len=%0d has=%b byte=%h ",
                         "idx=%0d last=%b"},
                        got.status, got.command, got.length, got.has, got.pbyte,
                        got.index, got.last);
            mismatches++;
         end else begin
            want = words_due.pop_front();
            if (got != want || rsp_tdata[31:28] != 4'h0) begin
               if (mismatches < 10)
                  $display({"rsp mismatch: expected st=%0d cmd=%h len=%0d has=%b byte=%h ",
                            "idx=%0d last=%b, got st=%0d cmd=%h len=%0d has=%b byte=%h ",
                            "idx=%0d last=%b pad=%h"},
                           want.status, want.command, want.length, want.has, want.pbyte,
                           want.index, want.last, got.status, got.command, got.length,
                           got.has, got.pbyte, got.index, got.last, rsp_tdata[31:28]);
               mismatches++;
            end
         end
      end
   end

   initial begin : rsp_sink
      int stall;
      @(posedge clock);
      forever begin
         if (long_hold_req) begin
            long_hold_req = 1'b0;
            stall = LONG_HOLD;
         end else begin
            stall = rx_idle ? $urandom_range(0, 10) : 0;
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
      end
   end

   initial begin : watchdog
      #2_000_000;
      $display("TEST FAILED");
      $finish;
   end

   initial begin : stimulus
      dir_row_type  row;
      rsp_word_type typed_word;
      int           phase_start;
      logic         paused;
      paused = 1'b0;
      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (dir_rows[r]) begin
         row = dir_rows[r];
         typed_word = '{status: row.status,
                        command: row.status == STATUS_OK ? row.cmd : 8'h00,
                        length: 6'd0, has: 1'b0, pbyte: 8'h00, index: 6'd0, last: 1'b1};
         send_byte(row.noise, 1'b0, '0);
         build_frame(row.addr, row.cmd, row.len, row.faults, row.alt);
         for (int i = 0; i < frame_bytes.size(); i++)
            send_byte(frame_bytes[i], row.typed && i == frame_bytes.size() - 1, typed_word);
      end

      for (int p = 0; p < NUM_PHASES; p++) begin
         write_station_addr(p == 0 ? 8'hFF : p == 2 ? 8'h00 : 8'($urandom_range(0, 255)));
         if (p == 2) long_hold_req = 1'b1;
         phase_start = bytes_sent;
         while (bytes_sent - phase_start < PHASE_BYTES) begin
            random_frame();
            if (p == 3 && !paused && bytes_sent - phase_start >= PHASE_BYTES / 2) begin
               drain_results();
               paused = 1'b1;
            end
         end
      end

      drain_results();
      if (mismatches == 0 && words_due.size() == 0)
         $display("TEST PASSED");
      else
         $display("TEST FAILED");
      $finish;
   end

endmodule

// File: sim.f
+incdir+design
design/ucfr_pkg.sv
design/ucfr_ram.sv
design/ucfr_ctrl.sv
design/ucfr_datapath.sv
design/uart_crc8_frame_receiver.sv
verif/uart_crc8_frame_receiver_tb.sv
